@@ design/lgbp_pkg.sv @@
// Shared constants, types and helper functions of the local/global branch predictor.
package lgbp_pkg;

  localparam int GHB        = 17;  // global history bits, also pattern index width
  localparam int LHB        = 14;  // local history bits, also local table index width
  localparam int PC_W       = 48;
  localparam int HIST_SHIFT = (GHB > LHB) ? (GHB - LHB) : 0;
  localparam int SUM_W      = LHB + HIST_SHIFT + 1;
  localparam int CLR_W      = (GHB > LHB) ? GHB : LHB;
  localparam int PAT_DEPTH  = 1 << GHB;
  localparam int LOC_DEPTH  = 1 << LHB;
  localparam int CLR_LAST   = ((PAT_DEPTH > LOC_DEPTH) ? PAT_DEPTH : LOC_DEPTH) - 1;

  localparam logic [1:0]     CTR_MAX     = 2'd3;
  localparam logic [1:0]     CTR_MIN     = 2'd0;
  localparam logic [1:0]     CTR_RESET   = 2'd2;
  localparam logic [LHB-1:0] LOCAL_RESET = LHB'(3);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_LOCAL,
    ST_RD_PAT
  } state_t;

  typedef struct packed {
    logic             in_ready;
    logic             accept;
    logic             issue_pat;
    logic             finish;
    logic             clr_pat_we;
    logic             clr_loc_we;
    logic [CLR_W-1:0] clr_addr;
  } ctrl_t;

  // Pattern index: ((pc << HIST_SHIFT) + local) xor global, low GHB bits.
  function automatic logic [GHB-1:0] pat_index(input logic [LHB-1:0] pc_lo,
                                               input logic [LHB-1:0] local_hist,
                                               input logic [GHB-1:0] ghist);
    logic [SUM_W-1:0] sum;
    sum = (SUM_W'(pc_lo) << HIST_SHIFT) + SUM_W'(local_hist);
    return GHB'(sum) ^ ghist;
  endfunction

  // Two-bit saturating counter update.
  function automatic logic [1:0] ctr_update(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

@@ design/lgbp_ram.sv @@
// Simple dual-port synchronous RAM with registered read data and read enable.
module lgbp_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/lgbp_ctrl.sv @@
// Sequencer of the branch predictor: clearing pass, then the read/update steps of each branch.
module lgbp_ctrl
  import lgbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t           state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             in_ready;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_RD_PAT) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_LAST)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_RD_LOCAL;
      end
      ST_RD_LOCAL: begin
        state_nxt = ST_RD_PAT;
      end
      ST_RD_PAT: begin
        if (out_free) state_nxt = accept ? ST_RD_LOCAL : ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.clr_addr   = clr_cnt_r;
    ctrl.in_ready   = in_ready;
    ctrl.accept     = accept;
    ctrl.issue_pat  = (state_r == ST_RD_LOCAL);
    ctrl.finish     = (state_r == ST_RD_PAT) && out_free;
    ctrl.clr_pat_we = (state_r == ST_CLEAR) && ((clr_cnt_r >> GHB) == '0);
    ctrl.clr_loc_we = (state_r == ST_CLEAR) && ((clr_cnt_r >> LHB) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

endmodule

@@ design/local_global_history_branch_predictor.sv @@
// Top level of the two-level local/global branch predictor with xor-indexed pattern counters.
// A transferred branch reads its local history, then its pattern counter (both synchronous
// RAMs); its prediction then goes to the output register once the result side is free.
// The reads are dependent: a branch is taken in only when idle or as the previous one finishes.
// Reset: rst_n is synchronous, active low; after reset a clearing pass writes every counter
// to weakly taken and every local history to 3, and no branch is taken meanwhile.
module local_global_history_branch_predictor
  import lgbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [PC_W-1:0] in_pc,
  input  logic            in_taken,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_predicted_taken
);

  ctrl_t ctrl;
  logic  out_free;

  // Branch context held while its two memory reads are in flight.
  logic [LHB-1:0] pc_lo_r;
  logic           taken_r;
  logic [GHB-1:0] pidx_r;
  logic [GHB-1:0] ghist_r, ghist_nxt;

  // The output register decouples the result side, so a new branch can be
  // transferred in while a finished prediction still waits.
  logic out_valid_r, out_valid_nxt;
  logic out_pred_r;

  // Local history table port signals.
  logic           loc_we;
  logic [LHB-1:0] loc_waddr;
  logic [LHB-1:0] loc_wdata;
  logic [LHB-1:0] loc_rdata;

  // Pattern counter table port signals.
  logic           pat_we;
  logic [GHB-1:0] pat_waddr;
  logic [1:0]     pat_wdata;
  logic [1:0]     pat_rdata;
  logic [GHB-1:0] pidx;

  assign out_free            = !out_valid_r || out_ready;
  assign in_ready            = ctrl.in_ready;
  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;

  lgbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // The pattern index needs the local history, which arrives in the cycle after
  // the transfer. The same cycle writes the shifted local history back, so the
  // next branch, whose local read is issued no earlier than the following edge,
  // always sees the updated entry.
  assign pidx = pat_index(pc_lo_r, loc_rdata, ghist_r);

  always_comb begin
    if (ctrl.clr_loc_we) begin
      loc_we    = 1'b1;
      loc_waddr = ctrl.clr_addr[LHB-1:0];
      loc_wdata = LOCAL_RESET;
    end else begin
      loc_we    = ctrl.issue_pat;
      loc_waddr = pc_lo_r;
      loc_wdata = {loc_rdata[LHB-2:0], taken_r};
    end
  end

  // The counter write lands at the same edge that may transfer in the next branch,
  // whose pattern read is only issued from the local-read step after it, so no overlap can occur.
  always_comb begin
    if (ctrl.clr_pat_we) begin
      pat_we    = 1'b1;
      pat_waddr = ctrl.clr_addr[GHB-1:0];
      pat_wdata = CTR_RESET;
    end else begin
      pat_we    = ctrl.finish;
      pat_waddr = pidx_r;
      pat_wdata = ctr_update(pat_rdata, taken_r);
    end
  end

  lgbp_ram #(
    .ADDR_W (LHB),
    .DATA_W (LHB)
  ) u_local_ram (
    .clk   (clk),
    .we    (loc_we),
    .waddr (loc_waddr),
    .wdata (loc_wdata),
    .re    (ctrl.accept),
    .raddr (in_pc[LHB-1:0]),
    .rdata (loc_rdata)
  );

  // Read data is only refreshed when a read is issued, so the counter stays
  // available while a stalled result side holds the branch in its last step.
  lgbp_ram #(
    .ADDR_W (GHB),
    .DATA_W (2)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (ctrl.issue_pat),
    .raddr (pidx),
    .rdata (pat_rdata)
  );

  always_comb begin
    ghist_nxt     = ghist_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (ctrl.finish) begin
      ghist_nxt     = {ghist_r[GHB-2:0], taken_r};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ghist_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ghist_r     <= ghist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      pc_lo_r <= in_pc[LHB-1:0];
      taken_r <= in_taken;
    end
    if (ctrl.issue_pat) begin
      pidx_r <= pidx;
    end
    if (ctrl.finish) begin
      out_pred_r <= pat_rdata[1];
    end
  end

endmodule
